// File: sv/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    MODE_PUSH_REAR  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_REAR   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_LIST       = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

endpackage

`default_nettype wire

// File: sv/double_ended_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// command   in         start high, busy low mode, item_value
// result    out        done (one cycle)     value, status, last
//
// Push and pop: result strobes in the cycle after accept,
// and busy stays low, so a new item may follow every cycle.
// List returns each stored value in turn, front to rear (one memory read port);
// busy is high while the values after the first are read.
// Reset clears front index, occupancy and control; entries stay unwritten.
// The receiver cannot stall; each result is shown for exactly one cycle.

module double_ended_queue_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [2:0]      mode,
  input  wire deq_pkg::data_t  item_value,
  output logic                 done,
  output deq_pkg::data_t       value,
  output logic [1:0]           status,
  output logic                 last
);
  import deq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 1;

  function automatic logic [IDX_W-1:0] pos_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    r = (p == IDX_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pos_dec(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    r = (p == '0) ? IDX_W'(CAPACITY - 1) : p - 1'b1;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pos_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(CAPACITY)) ? s - SUM_W'(CAPACITY) : s;
    return r[IDX_W-1:0];
  endfunction

  state_t            state, state_next;
  logic [IDX_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  occupancy, occupancy_next;
  logic [IDX_W-1:0]  list_pos, list_pos_next;
  logic [CNT_W-1:0]  list_left, list_left_next;
  logic              from_mem, from_mem_next;
  logic              done_next, last_next;
  status_t           status_q, status_next;

  logic              accept, full, empty;
  logic [SUM_W-1:0]  rear_sum, back_sum;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  data_t             rdata;

  assign accept   = start && !busy;
  assign full     = (occupancy == CNT_W'(CAPACITY));
  assign empty    = (occupancy == '0);
  assign rear_sum = {1'b0, front} + SUM_W'(occupancy);
  assign back_sum = rear_sum - 1'b1;

  always_comb begin
    state_next     = state;
    front_next     = front;
    occupancy_next = occupancy;
    list_pos_next  = list_pos;
    list_left_next = list_left;
    we             = 1'b0;
    waddr          = front;
    raddr          = list_pos;
    done_next      = 1'b0;
    status_next    = STAT_OK;
    last_next      = 1'b1;
    from_mem_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_PUSH_REAR: begin
              done_next = 1'b1;
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                we             = 1'b1;
                waddr          = pos_wrap(rear_sum);
                occupancy_next = occupancy + 1'b1;
              end
            end
            MODE_PUSH_FRONT: begin
              done_next = 1'b1;
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                we             = 1'b1;
                waddr          = pos_dec(front);
                front_next     = pos_dec(front);
                occupancy_next = occupancy + 1'b1;
              end
            end
            MODE_POP_REAR: begin
              done_next = 1'b1;
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                raddr          = pos_wrap(back_sum);
                from_mem_next  = 1'b1;
                occupancy_next = occupancy - 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              done_next = 1'b1;
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                raddr          = front;
                front_next     = pos_inc(front);
                from_mem_next  = 1'b1;
                occupancy_next = occupancy - 1'b1;
              end
            end
            MODE_LIST: begin
              done_next = 1'b1;
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                raddr          = front;
                from_mem_next  = 1'b1;
                last_next      = (occupancy == CNT_W'(1));
                list_pos_next  = pos_inc(front);
                list_left_next = occupancy - 1'b1;
                if (occupancy != CNT_W'(1)) begin
                  state_next = S_LIST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        raddr          = list_pos;
        done_next      = 1'b1;
        from_mem_next  = 1'b1;
        last_next      = (list_left == CNT_W'(1));
        list_pos_next  = pos_inc(list_pos);
        list_left_next = list_left - 1'b1;
        if (list_left == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      occupancy <= '0;
      list_left <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      occupancy <= occupancy_next;
      list_left <= list_left_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    list_pos <= list_pos_next;
    status_q <= status_next;
    last     <= last_next;
    from_mem <= from_mem_next;
  end

  deq_ram #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state == S_LIST);
  assign value  = from_mem ? rdata : '0;
  assign status = status_q;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_push_pop_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_PUSH_REAR || mode == MODE_PUSH_FRONT ||
      mode == MODE_POP_REAR || mode == MODE_POP_FRONT)) |=> (done && last))
    else $error("push or pop did not give one final item");

  a_list_run: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> done)
    else $error("list items not contiguous");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (last && value == '0))
    else $error("error status item not final or nonzero");
`endif

endmodule

`default_nettype wire

// File: sv/deq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire deq_pkg::data_t  wdata,
  input  wire logic [AW-1:0]   raddr,
  output deq_pkg::data_t       rdata
);
  import deq_pkg::*;

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sim/double_ended_queue_top_test.sv
`timescale 1ns / 1ps

module double_ended_queue_top_test;
  import deq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 90;

  typedef struct {
    data_t value;
    status_t status;
    logic last;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] mode = MODE_PUSH_REAR;
  data_t item_value = '0;
  logic busy;
  logic done;
  data_t value;
  logic [1:0] status;
  logic last;

  deque_result_t expected_results[$];
  data_t slot_value[CAPACITY];
  int head_pos = 0;
  int stored_count = 0;

  int mismatches = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  int push_items = 0;
  int pop_items = 0;
  int list_items = 0;
  int ignored_items = 0;
  int full_rejects = 0;
  int empty_answers = 0;
  bit no_idle = 1'b0;

  double_ended_queue_top #(.CAPACITY(CAPACITY)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .item_value(item_value),
    .done(done),
    .value(value),
    .status(status),
    .last(last)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  task automatic update_deque_model(input logic [2:0] m, input data_t v);
    int pos;
    int k;
    case (m)
      MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
        push_items++;
        if (stored_count >= CAPACITY) begin
          full_rejects++;
          expected_results.push_back('{value: '0, status: STAT_FULL, last: 1'b1});
        end else begin
          if (m == MODE_PUSH_REAR) begin
            pos = (head_pos + stored_count) % CAPACITY;
          end else begin
            head_pos = (head_pos + CAPACITY - 1) % CAPACITY;
            pos = head_pos;
          end
          slot_value[pos] = v;
          stored_count++;
          expected_results.push_back('{value: '0, status: STAT_OK, last: 1'b1});
        end
      end
      MODE_POP_REAR, MODE_POP_FRONT: begin
        pop_items++;
        if (stored_count == 0) begin
          empty_answers++;
          expected_results.push_back('{value: '0, status: STAT_EMPTY, last: 1'b1});
        end else begin
          if (m == MODE_POP_REAR) begin
            pos = (head_pos + stored_count - 1) % CAPACITY;
          end else begin
            pos = head_pos;
            head_pos = (head_pos + 1) % CAPACITY;
          end
          stored_count--;
          expected_results.push_back('{value: slot_value[pos], status: STAT_OK, last: 1'b1});
        end
      end
      MODE_LIST: begin
        list_items++;
        if (stored_count == 0) begin
          empty_answers++;
          expected_results.push_back('{value: '0, status: STAT_EMPTY, last: 1'b1});
        end else begin
          for (k = 0; k < stored_count; k++) begin
            expected_results.push_back('{value: slot_value[(head_pos + k) % CAPACITY],
                                         status: STAT_OK,
                                         last: (k == stored_count - 1)});
          end
        end
      end
      default: ignored_items++;
    endcase
  endtask

  // hold start high across back-to-back items; lower it only for a gap
  task automatic send_item(input logic [2:0] m, input data_t v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    item_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    update_deque_model(m, v);
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected item value=%0d status=%0d last=%0b",
                                value, status, last));
      end else begin
        results_checked++;
        if (value !== expected_results[0].value || status !== expected_results[0].status ||
            last !== expected_results[0].last) begin
          note_mismatch($sformatf("expected value=%0d status=%0d last=%0b, got %0d/%0d/%0b",
                                  expected_results[0].value, expected_results[0].status,
                                  expected_results[0].last, value, status, last));
        end
        void'(expected_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles, %0d results pending",
               idle_cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_queue();
    send_item(MODE_POP_REAR, 32'sd5);
    send_item(MODE_POP_FRONT, -32'sd5);
    send_item(MODE_LIST, '1);
  endtask

  task automatic test_ignored_modes();
    send_item(3'd5, 32'sd1);
    send_item(3'd6, 32'sd2);
    send_item(3'd7, 32'sd3);
  endtask

  task automatic test_fill_and_full();
    data_t fill_values[CAPACITY];
    int i;
    fill_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
                    32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0000_0001, 32'shFFFF_FFFE,
                    32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F, 32'shF0F0_F0F0,
                    32'sh00FF_00FF, 32'shFF00_FF00, 32'sh8000_0001, 32'sh7FFF_FFFE};
    for (i = 0; i < CAPACITY; i++) begin
      send_item(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_REAR, fill_values[i]);
    end
    send_item(MODE_PUSH_REAR, 32'sh7FFF_FFFF);
    send_item(MODE_PUSH_FRONT, 32'sh8000_0000);
  endtask

  task automatic test_list_and_pops();
    send_item(MODE_LIST, '0);
    send_item(MODE_POP_FRONT, '0);
    send_item(MODE_POP_REAR, '0);
  endtask

  task automatic test_random_traffic();
    int counted;
    int pick;
    bit fill_bias;
    logic [2:0] m;
    data_t v;
    counted = 0;
    fill_bias = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 20 == 0) begin
        fill_bias = ~fill_bias;
        no_idle = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        m = 3'($urandom_range(5, 7));
      end else if (pick < 14) begin
        m = MODE_LIST;
      end else if ($urandom_range(0, 99) < (fill_bias ? 75 : 25)) begin
        m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
      end else begin
        m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
      end
      case ($urandom_range(0, 9))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7FFF_FFFF;
        default: v = $urandom;
      endcase
      send_item(m, v);
      if (m <= MODE_LIST) counted++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_ignored_modes();
    test_fill_and_full();
    test_list_and_pops();
    test_random_traffic();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_mismatch($sformatf("%0d expected items never arrived", expected_results.size()));
    end
    $display("Sent %0d pushes, %0d pops, %0d lists and %0d undefined modes; %0d results checked",
             push_items, pop_items, list_items, ignored_items, results_checked);
    $display("Full rejects: %0d, empty answers: %0d, mismatches: %0d",
             full_rejects, empty_answers, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
